@@ design/teq_pkg.sv @@
// Shared types and constants for the timed event queue.
package teq_pkg;
   localparam int QueueDepth = 64;
   localparam int TimeBits   = 32;
   localparam int EventBits  = 32;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_POP     = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NONE     = 2'd1,
      ST_FULL     = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request fields
      logic insert;   // sorted insert of captured event
      logic remove;   // shift out head
      logic advance;  // now <= head time
      logic set_rsp;  // capture result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic overflow;
      logic head_due;
      logic empty;
   } stat_type;
endpackage

@@ design/teq_datapath.sv @@
// Shift-cell store, current time and result register of the timed event queue.
module teq_datapath #(
   parameter int QUEUE_DEPTH = teq_pkg::QueueDepth,
   parameter int TIME_BITS   = teq_pkg::TimeBits,
   parameter int EVENT_BITS  = teq_pkg::EventBits,
   localparam int CntBits    = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [31:0]             csr_wdata,
   input  logic [1:0]              op,
   input  logic [TIME_BITS-1:0]    delay,
   input  logic [EVENT_BITS-1:0]   event_in,
   input  teq_pkg::cmd_type        cmd,
   output teq_pkg::stat_type       stat,
   output logic [1:0]              status,
   output logic [EVENT_BITS-1:0]   event_out,
   output logic [TIME_BITS-1:0]    current_time,
   output logic [CntBits-1:0]      pending_count
);
   logic [TIME_BITS-1:0]  slot_time_ff    [QUEUE_DEPTH];
   logic [EVENT_BITS-1:0] slot_payload_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] slot_valid_ff;
   logic [CntBits-1:0]    held_count_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic [1:0]            op_ff;
   logic [TIME_BITS-1:0]  due_ff;
   logic                  ovf_ff;
   logic [EVENT_BITS-1:0] pay_ff;
   logic [1:0]            status_ff;
   logic [EVENT_BITS-1:0] event_out_ff;
   logic [TIME_BITS:0]    sum;
   logic [QUEUE_DEPTH-1:0] later;   // cell holds a time strictly after due
   logic [1:0]            st_in;

   assign sum = {1'b0, now_ff} + {1'b0, delay};

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         later[i] = slot_valid_ff[i] && (slot_time_ff[i] > due_ff);
      end
   end

   assign stat.full     = (held_count_ff == CntBits'(QUEUE_DEPTH));
   assign stat.overflow = ovf_ff;
   assign stat.empty    = ~slot_valid_ff[0];
   assign stat.head_due = slot_valid_ff[0] && (slot_time_ff[0] == now_ff);

   always_comb begin
      st_in = teq_pkg::ST_NONE;
      case (op_ff)
         teq_pkg::OP_ADD: begin
            if (stat.full) st_in = teq_pkg::ST_FULL;
            else if (ovf_ff) st_in = teq_pkg::ST_OVERFLOW;
            else st_in = teq_pkg::ST_DONE;
         end
         teq_pkg::OP_POP: st_in = stat.head_due ? teq_pkg::ST_DONE : teq_pkg::ST_NONE;
         teq_pkg::OP_ADVANCE: begin
            st_in = (!stat.empty && !stat.head_due) ? teq_pkg::ST_DONE : teq_pkg::ST_NONE;
         end
         default: st_in = teq_pkg::ST_NONE;
      endcase
   end

   // Each cell takes from its left neighbor, keeps, takes the new event, or
   // takes from its right neighbor; the new event lands at the first later cell, else at the first free cell.
   // A cell whose left neighbor is later always shifts, the free tail cell too.
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         slot_valid_ff <= '0;
         held_count_ff <= '0;
         now_ff        <= reset ? '0 : TIME_BITS'(csr_wdata);
      end else begin
         if (cmd.load) begin
            op_ff  <= op;
            due_ff <= sum[TIME_BITS-1:0];
            ovf_ff <= sum[TIME_BITS];
            pay_ff <= event_in;
         end
         if (cmd.insert) begin
            if (later[0] || !slot_valid_ff[0]) begin
               slot_time_ff[0]    <= due_ff;
               slot_payload_ff[0] <= pay_ff;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
               if (later[i-1]) begin
                  slot_time_ff[i]    <= slot_time_ff[i-1];
                  slot_payload_ff[i] <= slot_payload_ff[i-1];
               end else if (later[i] || (!slot_valid_ff[i] && slot_valid_ff[i-1])) begin
                  slot_time_ff[i]    <= due_ff;
                  slot_payload_ff[i] <= pay_ff;
               end
            end
            slot_valid_ff <= {slot_valid_ff[QUEUE_DEPTH-2:0], 1'b1};
            held_count_ff <= held_count_ff + 1'b1;
         end
         if (cmd.remove) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
               slot_time_ff[i]    <= slot_time_ff[i+1];
               slot_payload_ff[i] <= slot_payload_ff[i+1];
            end
            slot_valid_ff <= {1'b0, slot_valid_ff[QUEUE_DEPTH-1:1]};
            held_count_ff <= held_count_ff - 1'b1;
         end
         if (cmd.advance) now_ff <= slot_time_ff[0];
         if (cmd.set_rsp) begin
            status_ff    <= st_in;
            event_out_ff <= (op_ff == teq_pkg::OP_POP && st_in == teq_pkg::ST_DONE)
                            ? slot_payload_ff[0] : '0;
         end
      end
   end

   assign status        = status_ff;
   assign event_out     = event_out_ff;
   assign current_time  = now_ff;
   assign pending_count = held_count_ff;
endmodule

@@ design/teq_ctrl.sv @@
// Controller state machine of the timed event queue.
module teq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [1:0]        op,
   input  teq_pkg::stat_type stat,
   output teq_pkg::cmd_type  cmd
);
   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_type;
   state_type state_ff;
   logic [1:0] op_ff;
   logic       ok;

   always_comb begin
      case (op_ff)
         teq_pkg::OP_ADD:     ok = !stat.full && !stat.overflow;
         teq_pkg::OP_POP:     ok = stat.head_due;
         teq_pkg::OP_ADVANCE: ok = !stat.empty && !stat.head_due;
         default:             ok = 1'b0;
      endcase
   end

   assign req_tready  = (state_ff == S_IDLE) && !csr_we;
   assign rsp_tvalid  = (state_ff == S_OUT);
   assign cmd.load    = req_tvalid && req_tready;
   assign cmd.set_rsp = (state_ff == S_EXEC);
   assign cmd.insert  = cmd.set_rsp && ok && op_ff == teq_pkg::OP_ADD;
   assign cmd.remove  = cmd.set_rsp && ok && op_ff == teq_pkg::OP_POP;
   assign cmd.advance = cmd.set_rsp && ok && op_ff == teq_pkg::OP_ADVANCE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (cmd.load) begin
               state_ff <= S_EXEC;
               op_ff    <= op;
            end
            S_EXEC: state_ff <= S_OUT;
            S_OUT:  if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.insert, cmd.remove, cmd.advance}) <= 1)
      else $error("more than one store action");
   a_exec_then_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> state_ff == S_OUT)
      else $error("exec not followed by result");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while result pending");
endmodule

@@ design/timed_event_queue.sv @@
// A request is taken in S_IDLE and worked in S_EXEC in the cycle after; its result is
// registered and valid in S_OUT until it is taken.
// A new request is taken only in S_IDLE, after the result has been taken (take,
// execute, hand out), since the input waits for the result.
// Reset (synchronous, high): empties the store, current time 0.
// A csr write empties the store and loads the current time.
module timed_event_queue #(
   parameter int QUEUE_DEPTH = teq_pkg::QueueDepth,
   parameter int TIME_BITS   = teq_pkg::TimeBits,
   parameter int EVENT_BITS  = teq_pkg::EventBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // opcode[1:0], delay[33:2], event_in[65:34], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata   // status[1:0], event_out[33:2], time[65:34], count[72:66]
);
   localparam int CntBits = $clog2(QUEUE_DEPTH + 1);
   teq_pkg::cmd_type  cmd;
   teq_pkg::stat_type stat;
   logic [1:0]            status;
   logic [EVENT_BITS-1:0] event_out;
   logic [TIME_BITS-1:0]  current_time;
   logic [CntBits-1:0]    pending_count;

   teq_ctrl u_ctrl (
      .clock, .reset, .csr_we, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .op(req_tdata[1:0]), .stat, .cmd
   );

   teq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS),
                  .EVENT_BITS(EVENT_BITS)) u_dp (
      .clock, .reset, .csr_we, .csr_wdata,
      .op(req_tdata[1:0]),
      .delay(TIME_BITS'(req_tdata[33:2])),
      .event_in(EVENT_BITS'(req_tdata[65:34])),
      .cmd, .stat, .status, .event_out, .current_time, .pending_count
   );

   assign rsp_tdata = {7'd0, 7'(pending_count), 32'(current_time), 32'(event_out), status};
endmodule
